@@ hdl/cvd_pkg.sv @@
// Shared types and constants for the canonical varint decoder.
// Holds the word record passed from the front end to the back end; no dependencies.
`default_nettype none

package cvd_pkg;

  // Last byte position of a varint in each mode (maximum length minus one).
  localparam logic [3:0] LAST_NARROW = 4'd4;
  localparam logic [3:0] LAST_WIDE   = 4'd9;

  // Final-byte limits at maximum length and the continuation bit.
  localparam logic [7:0] LIMIT_NARROW = 8'h10;
  localparam logic [7:0] LIMIT_WIDE   = 8'h02;
  localparam logic [7:0] CONT_BIT     = 8'h80;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TRUNC = 2'd1,
    ERR_ZERO  = 2'd2,
    ERR_LARGE = 2'd3
  } err_t;

  // One classified word, as the front end hands it to the back end.
  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] pos;
    logic       copy_valid;
    logic       done;
    logic       ok;
    err_t       err;
    logic       acc_add;
    logic       acc_restart;
    logic       value_en;
  } op_t;

  // Bit offset of the seven data bits at a byte position of a 32-bit varint.
  function automatic logic [4:0] shift_of(input logic [3:0] pos);
    logic [4:0] s;
    case (pos)
      4'd0: s = 5'd0;
      4'd1: s = 5'd7;
      4'd2: s = 5'd14;
      4'd3: s = 5'd21;
      4'd4: s = 5'd28;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hdl/canonical_varint_decoder_core.sv @@
// Top level of the canonical varint decoder: mode register, front end,
// word queue and back end. Depends on cvd_pkg, cvd_front, cvd_queue, cvd_back.
`default_nettype none

// The block reads a byte stream of little-endian base-128 varints, one input
// word per byte, and returns exactly one result word for every input word.
// Each varint is checked for canonical form: a varint longer than one byte
// must not end in a zero byte, and a varint at maximum length (5 bytes for
// 32-bit values, 10 for 64-bit) must end in a byte of at most 0x0F or 0x01.
// With wide_mode clear the 32-bit value is built and reported on the word
// that ends the varint; with wide_mode set each byte is echoed on copy_byte
// for copying, except a rejected final byte at maximum length. A word with
// source_empty set ends a pending varint as truncated and otherwise yields
// an all-zero result. Throughput is one word per cycle while out_stall stays
// low. The front end classifies a word in the cycle it is accepted and writes
// it into a two-entry queue; from the queue head the back end applies it to
// the accumulator and loads the output register, which raises out_valid.
// Writing wide_mode restarts the decoder; write it only while the block is
// idle.

module canonical_varint_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: the single wide_mode register.
  input  wire logic        cfg_write,
  input  wire logic        cfg_data,
  // Input words.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        source_empty,
  // Result words.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       copy_byte,
  output logic             copy_valid,
  output logic             varint_done,
  output logic             varint_ok,
  output logic [1:0]       error_code,
  output logic [31:0]      decoded_value
);
  import cvd_pkg::*;

  logic wide_mode;
  logic accept;
  logic take;
  logic q_full;
  logic q_empty;
  op_t  front_op;
  op_t  head_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode <= 1'b0;
    end else if (cfg_write) begin
      wide_mode <= cfg_data;
    end
  end

  // The queue absorbs a word while the output register waits to be taken.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // The back end moves the queue head into the output register whenever
  // that register is empty or is being taken in this cycle.
  assign take = !q_empty && (!out_valid || !out_stall);

  cvd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .wide_mode    (wide_mode),
    .restart      (cfg_write),
    .accept       (accept),
    .data_byte    (data_byte),
    .source_empty (source_empty),
    .op           (front_op)
  );

  cvd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (accept),
    .push_op (front_op),
    .pop     (take),
    .head_op (head_op),
    .full    (q_full),
    .empty   (q_empty)
  );

  cvd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .restart       (cfg_write),
    .take          (take),
    .op            (head_op),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .copy_byte     (copy_byte),
    .copy_valid    (copy_valid),
    .varint_done   (varint_done),
    .varint_ok     (varint_ok),
    .error_code    (error_code),
    .decoded_value (decoded_value)
  );

endmodule

`default_nettype wire

@@ hdl/cvd_front.sv @@
// Front end of the canonical varint decoder: tracks the byte position and
// classifies each accepted word into an op_t record. Depends on cvd_pkg.
`default_nettype none

module cvd_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wide_mode,
  input  wire logic        restart,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        source_empty,
  output cvd_pkg::op_t     op
);
  import cvd_pkg::*;

  logic [3:0] byte_position;
  logic [3:0] byte_position_next;
  logic [3:0] last;
  logic [7:0] limit;
  logic [3:0] pos_c;

  always_comb begin
    last  = wide_mode ? LAST_WIDE : LAST_NARROW;
    limit = wide_mode ? LIMIT_WIDE : LIMIT_NARROW;
    pos_c = (byte_position > last) ? last : byte_position;

    op = '0;
    op.data_byte = data_byte;
    op.pos = pos_c;
    op.err = ERR_NONE;
    byte_position_next = byte_position;

    if (source_empty) begin
      // An empty source only matters when a varint is pending.
      if (byte_position != 4'd0) begin
        op.done = 1'b1;
        op.err = ERR_TRUNC;
        op.acc_restart = 1'b1;
        byte_position_next = 4'd0;
      end
    end else if (pos_c == last) begin
      op.done = 1'b1;
      op.acc_restart = 1'b1;
      byte_position_next = 4'd0;
      if (data_byte >= limit) begin
        op.err = ERR_LARGE;
      end else if (data_byte == 8'd0) begin
        op.err = ERR_ZERO;
      end else begin
        op.ok = 1'b1;
        op.copy_valid = wide_mode;
        op.value_en = !wide_mode;
      end
    end else begin
      op.copy_valid = wide_mode;
      op.acc_add = !wide_mode;
      if (data_byte < CONT_BIT) begin
        op.done = 1'b1;
        op.acc_restart = 1'b1;
        byte_position_next = 4'd0;
        if (pos_c != 4'd0 && data_byte == 8'd0) begin
          op.err = ERR_ZERO;
        end else begin
          op.ok = 1'b1;
          op.value_en = !wide_mode;
        end
      end else begin
        byte_position_next = pos_c + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      byte_position <= 4'd0;
    end else if (accept) begin
      byte_position <= byte_position_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/cvd_queue.sv @@
// Two-entry queue of classified words between front end and back end.
// Depends on cvd_pkg for the op_t record.
`default_nettype none

module cvd_queue (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire cvd_pkg::op_t push_op,
  input  wire logic    pop,
  output cvd_pkg::op_t head_op,
  output logic         full,
  output logic         empty
);
  import cvd_pkg::*;

  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign head_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/cvd_back.sv @@
// Back end of the canonical varint decoder: holds the offset accumulator and
// the output register for result words. Depends on cvd_pkg.
`default_nettype none

module cvd_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        restart,
  input  wire logic        take,
  input  wire cvd_pkg::op_t op,
  input  wire logic        out_stall,
  output logic             out_valid,
  output logic [7:0]       copy_byte,
  output logic             copy_valid,
  output logic             varint_done,
  output logic             varint_ok,
  output logic [1:0]       error_code,
  output logic [31:0]      decoded_value
);
  import cvd_pkg::*;

  logic [31:0] accumulator;
  logic [31:0] addend;
  logic [31:0] sum;

  // Each byte contributes (byte - 1) at its offset; the accumulator starts at
  // one, so the offsets cancel and the wrap of the low bits is harmless.
  always_comb begin
    addend = ({24'd0, op.data_byte} - 32'd1) << shift_of(op.pos);
    sum    = accumulator + addend;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      accumulator <= 32'd1;
    end else if (take) begin
      if (op.acc_restart) begin
        accumulator <= 32'd1;
      end else if (op.acc_add) begin
        accumulator <= sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      copy_byte     <= op.copy_valid ? op.data_byte : 8'd0;
      copy_valid    <= op.copy_valid;
      varint_done   <= op.done;
      varint_ok     <= op.ok;
      error_code    <= op.err;
      decoded_value <= op.value_en ? sum : 32'd0;
    end
  end

endmodule

`default_nettype wire

@@ sim/tb_canonical_varint_decoder_core.sv @@
// Self-checking testbench for canonical_varint_decoder_core.
// A scoreboard class predicts one result word per accepted input word and compares in order.
// Depends on cvd_pkg for the error codes and the mode constants, and on the RTL under hdl.
`timescale 1ns / 100ps

module tb_canonical_varint_decoder_core;
  import cvd_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 9;
  // Cycles the receiver holds off in the back-pressure phase. This is long enough
  // to fill the internal queue and push in_stall high.
  localparam int HOLD_CYCLES  = 60;
  // Cycles let pass after the last result before a mode write or the end.
  localparam int DRAIN_CYCLES = 8;
  // Cycles without any handshake before the run is declared hung. The longest
  // quiet stretch in a correct run is the hold-off plus a random gap.
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_WORDS  = 250;

  localparam logic MODE_NARROW = 1'b0;
  localparam logic MODE_WIDE   = 1'b1;

  // One result word as the block reports it.
  typedef struct {
    logic [7:0]  copy_byte;
    logic        copy_valid;
    logic        done;
    logic        ok;
    err_t        err;
    logic [31:0] value;
  } varint_result_t;

  // One input word as the sender offers it.
  typedef struct {
    logic [7:0] data;
    logic       empty;
  } stim_word_t;

  // Mirrors the decoder state and keeps the results still owed by the block.
  class varint_scoreboard;
    logic           wide;
    logic [3:0]     position;
    logic [31:0]    acc;
    varint_result_t owed[$];
    int             failures;

    function new();
      wide     = MODE_NARROW;
      failures = 0;
      restart();
    endfunction

    // The accumulator carries a +1 offset. Each byte then adds (byte - 1)
    // at its shift, and the offsets cancel out over a complete varint.
    function void restart();
      position = 4'd0;
      acc      = 32'd1;
    endfunction

    function void load_mode(logic mode);
      wide = mode;
      restart();
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Predicts the result of one accepted input word and queues it.
    function void take_word(logic [7:0] b, logic empty);
      varint_result_t r;
      logic [3:0]     last;
      logic [3:0]     pos;
      logic [7:0]     limit;
      logic [31:0]    addend;
      r.copy_byte  = 8'd0;
      r.copy_valid = 1'b0;
      r.done       = 1'b0;
      r.ok         = 1'b0;
      r.err        = ERR_NONE;
      r.value      = 32'd0;
      last   = wide ? LAST_WIDE : LAST_NARROW;
      limit  = wide ? LIMIT_WIDE : LIMIT_NARROW;
      pos    = (position > last) ? last : position;
      addend = {24'd0, b} - 32'd1;
      if (empty) begin
        // An empty source only matters when a varint is pending.
        if (position != 4'd0) begin
          r.done = 1'b1;
          r.err  = ERR_TRUNC;
          restart();
        end
      end else if (pos == last) begin
        // At maximum length the limit check comes before the zero check.
        // A rejected byte is never echoed.
        r.done = 1'b1;
        if (b >= limit) begin
          r.err = ERR_LARGE;
        end else if (b == 8'd0) begin
          r.err = ERR_ZERO;
        end else begin
          r.ok = 1'b1;
          if (wide) begin
            r.copy_byte  = b;
            r.copy_valid = 1'b1;
          end else begin
            r.value = acc + (addend << (7 * LAST_NARROW));
          end
        end
        restart();
      end else begin
        if (wide) begin
          r.copy_byte  = b;
          r.copy_valid = 1'b1;
        end else begin
          acc = acc + (addend << (7 * pos));
        end
        if (b < CONT_BIT) begin
          r.done = 1'b1;
          if (pos > 4'd0 && b == 8'd0) begin
            r.err = ERR_ZERO;
          end else begin
            r.ok = 1'b1;
            if (!wide) r.value = acc;
          end
          restart();
        end else begin
          position = pos + 4'd1;
        end
      end
      owed.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        failures++;
      end
    endfunction

    // Compares one accepted result word with the oldest prediction.
    function void match_result(varint_result_t got);
      varint_result_t want;
      if (owed.size() == 0) begin
        $display("%0t: result word with nothing expected, actual done %0b err %0d",
                 $time, got.done, got.err);
        failures++;
        return;
      end
      want = owed.pop_front();
      check_field("copy_byte", 32'(want.copy_byte), 32'(got.copy_byte));
      check_field("copy_valid", 32'(want.copy_valid), 32'(got.copy_valid));
      check_field("varint_done", 32'(want.done), 32'(got.done));
      check_field("varint_ok", 32'(want.ok), 32'(got.ok));
      check_field("error_code", 32'(want.err), 32'(got.err));
      check_field("decoded_value", want.value, got.value);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        source_empty;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  copy_byte;
  logic        copy_valid;
  logic        varint_done;
  logic        varint_ok;
  logic [1:0]  error_code;
  logic [31:0] decoded_value;

  varint_scoreboard sb;
  stim_word_t       plan[$];
  // Turns off the random idling on both sides for a whole phase.
  bit               quiet;
  // Set by the sender to ask the receiver for one long hold-off. The receiver clears it.
  bit               hold_request;
  int               idle_cycles;

  canonical_varint_decoder_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .source_empty  (source_empty),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .copy_byte     (copy_byte),
    .copy_valid    (copy_valid),
    .varint_done   (varint_done),
    .varint_ok     (varint_ok),
    .error_code    (error_code),
    .decoded_value (decoded_value)
  );

  always #(CLK_HALF) clk = ~clk;

  // Both channels are sampled at the rising edge. Inputs only change at the
  // falling edge, so the values read here are the settled ones from before the edge.
  // The input word is noted first. A result word passes the queue and the output register,
  // so a result word at this edge never belongs to the input word taken at the same edge.
  always @(posedge clk) begin
    varint_result_t got;
    if (!rst) begin
      if (in_valid && !in_stall) sb.take_word(data_byte, source_empty);
      if (out_valid && !out_stall) begin
        got.copy_byte  = copy_byte;
        got.copy_valid = copy_valid;
        got.done       = varint_done;
        got.ok         = varint_ok;
        got.err        = err_t'(error_code);
        got.value      = decoded_value;
        sb.match_result(got);
      end
    end
  end

  // The watchdog counts cycles in which neither channel completes a handshake.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL canonical_varint_decoder_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver stalls at random, or not at all in a quiet phase. On request it
  // holds off for a long stretch that it counts itself.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 17);
      end
    end
  end

  task automatic add_word(logic [7:0] d, logic e);
    stim_word_t w;
    w.data  = d;
    w.empty = e;
    plan.push_back(w);
  endtask

  // Offers every planned word in turn. Each word is held until it is accepted.
  // The task starts and ends at a falling edge.
  task automatic run_plan();
    stim_word_t w;
    while (plan.size() != 0) begin
      w = plan.pop_front();
      while (!quiet && $urandom_range(0, 99) < 17) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid     <= 1'b1;
      data_byte    <= w.data;
      source_empty <= w.empty;
      do @(posedge clk); while (in_stall);
      @(negedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // Waits until every predicted result has come, then lets the pipeline settle.
  task automatic settle();
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // A mode write restarts the decoder. This happens even mid-varint and even
  // when the value does not change.
  task automatic write_mode(logic mode);
    cfg_write <= 1'b1;
    cfg_data  <= mode;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.load_mode(mode);
  endtask

  // Plans one random varint, mostly well-formed with random content. A minority of
  // cases are stray bytes, empty-source words, truncations, and broken final bytes.
  task automatic plan_varint(logic wide);
    int         max_len;
    int         len;
    int         kind;
    logic [7:0] limit;
    logic [7:0] final_byte;
    max_len = wide ? int'(LAST_WIDE) + 1 : int'(LAST_NARROW) + 1;
    limit   = wide ? LIMIT_WIDE : LIMIT_NARROW;
    kind    = $urandom_range(0, 99);
    if (kind < 6) begin
      add_word(8'($urandom_range(0, 255)), 1'b0);
      return;
    end
    if (kind < 10) begin
      add_word(8'($urandom_range(0, 255)), 1'b1);
      return;
    end
    // Most varints are short. A good share run to the maximum length so that
    // the final-byte limit is reached often.
    if ($urandom_range(0, 99) < 55) len = $urandom_range(1, 3);
    else if ($urandom_range(0, 99) < 50) len = max_len;
    else len = $urandom_range(1, max_len);
    repeat (len - 1) add_word(CONT_BIT | 8'($urandom_range(0, 127)), 1'b0);
    if (kind < 18) begin
      // The source runs dry where the final byte should be.
      add_word(8'($urandom_range(0, 255)), 1'b1);
      return;
    end
    if (len == max_len) begin
      if (kind < 28) final_byte = 8'($urandom_range(limit, 255));
      else if (kind < 34) final_byte = 8'd0;
      else final_byte = 8'($urandom_range(1, limit - 1));
    end else if (len == 1) begin
      final_byte = 8'($urandom_range(0, 127));
    end else begin
      if (kind < 28) final_byte = 8'd0;
      else final_byte = 8'($urandom_range(1, 127));
    end
    add_word(final_byte, 1'b0);
  endtask

  task automatic plan_random_phase(logic wide);
    while (plan.size() < PHASE_WORDS) plan_varint(wide);
  endtask

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_data     = 1'b0;
    in_valid     = 1'b0;
    data_byte    = 8'd0;
    source_empty = 1'b0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    sb           = new();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed narrow cases: a lone zero, the largest one-byte value, the
    // largest 32-bit value, a trailing zero, an empty source while idle, a
    // truncated varint, and a final byte at maximum length that is too large
    // or zero.
    write_mode(MODE_NARROW);
    add_word(8'h00, 1'b0);
    add_word(8'h7F, 1'b0);
    repeat (4) add_word(8'hFF, 1'b0);
    add_word(8'h0F, 1'b0);
    add_word(8'h80, 1'b0);
    add_word(8'h00, 1'b0);
    add_word(8'h5A, 1'b1);
    add_word(8'h85, 1'b0);
    add_word(8'hFF, 1'b1);
    repeat (4) add_word(8'h80, 1'b0);
    add_word(8'h10, 1'b0);
    repeat (4) add_word(8'h80, 1'b0);
    add_word(8'h00, 1'b0);
    run_plan();
    settle();

    // Directed wide cases: the largest 64-bit value, an echoed trailing zero,
    // truncation, and a rejected final byte with bit 7 set at maximum length.
    write_mode(MODE_WIDE);
    repeat (9) add_word(8'hFF, 1'b0);
    add_word(8'h01, 1'b0);
    add_word(8'h81, 1'b0);
    add_word(8'h00, 1'b0);
    add_word(8'h83, 1'b0);
    add_word(8'h00, 1'b1);
    repeat (9) add_word(8'h80, 1'b0);
    add_word(8'hFF, 1'b0);
    run_plan();
    settle();

    // Random phases alternate between the two modes. Any varint left unfinished
    // at the end of a phase is dropped by the next mode write.
    write_mode(MODE_NARROW);
    plan_random_phase(MODE_NARROW);
    run_plan();
    settle();

    // This phase runs at full rate with no idling on either side.
    quiet = 1'b1;
    write_mode(MODE_WIDE);
    plan_random_phase(MODE_WIDE);
    run_plan();
    quiet = 1'b0;
    settle();

    // The receiver holds off while the sender keeps offering words. The block
    // fills up and must stall its input.
    write_mode(MODE_NARROW);
    hold_request = 1'b1;
    plan_random_phase(MODE_NARROW);
    run_plan();
    settle();

    // A rewrite of the same mode exercises the restart alone.
    write_mode(MODE_WIDE);
    write_mode(MODE_WIDE);
    plan_random_phase(MODE_WIDE);
    run_plan();
    settle();

    if (sb.failures == 0) begin
      $display("PASS canonical_varint_decoder_core");
    end else begin
      $display("FAIL canonical_varint_decoder_core");
    end
    $finish;
  end

endmodule
